// ===== rtl/core/nearest_point_on_polyline_unit_defines.svh =====
// Assertion macros for the nearest point unit
`ifndef NEAREST_POINT_ON_POLYLINE_UNIT_DEFINES_SVH
`define NEAREST_POINT_ON_POLYLINE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define NPP_ASSERT_IMPL(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define NPP_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define NPP_ASSERT_IMPL(lbl, clk, rst_n, a, c, msg)
`define NPP_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg)
`endif
`endif

// ===== rtl/core/npp_pkg.sv =====
package npp_pkg;
    localparam int MAX_POINTS_DEF = 256;
    localparam int CW = 24;
    localparam int DW = 25;
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;
    localparam logic [DW-1:0] DIST_MAX = {DW{1'b1}};

    typedef struct packed {
        logic load_a;     // latch vertex a from memory read data
        logic load_b;     // latch vertex b, form segment terms
        logic mul_dp;     // compute dot and length products
        logic div_start;  // begin fraction division
        logic mul_off;    // offset products
        logic form_pt;    // rounded point
        logic mul_dd;     // deltas, squared by the free-running sq_reg
        logic sqrt_start; // begin square root
        logic compare;    // update best
        logic clr_best;
    } npp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic skip;       // zero length segment
    } npp_sts_t;
endpackage

// ===== rtl/core/npp_datapath.sv =====
`include "nearest_point_on_polyline_unit_defines.svh"
module npp_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  npp_pkg::npp_cmd_t             cmd,
    output npp_pkg::npp_sts_t             sts,
    input  logic signed [npp_pkg::CW-1:0] rd_x,
    input  logic signed [npp_pkg::CW-1:0] rd_y,
    input  logic signed [npp_pkg::CW-1:0] cx,
    input  logic signed [npp_pkg::CW-1:0] cy,
    output logic signed [npp_pkg::CW-1:0] best_x,
    output logic signed [npp_pkg::CW-1:0] best_y,
    output logic [npp_pkg::DW-1:0]        best_d,
    output logic                          best_found
);
    logic signed [25:0] ax_reg, ay_reg, abx_reg, aby_reg, cax_reg, cay_reg;
    logic signed [51:0] dp_reg;
    logic [51:0] len2_reg;
    logic [16:0] t_reg;
    logic [51:0] drem_reg;
    logic [15:0] dq_reg;
    logic [4:0] dcnt_reg;
    logic div_busy_reg;
    logic signed [43:0] ox_reg, oy_reg;
    logic signed [26:0] px_reg, py_reg, dx_reg, dy_reg;
    logic [53:0] sq_reg;
    logic [53:0] sv_reg;
    logic [53:0] sres_reg;
    logic [5:0] scnt_reg;
    logic sq_busy_reg;
    logic [npp_pkg::DW-1:0] d_clamp;
    logic signed [npp_pkg::CW-1:0] bx_reg, by_reg;
    logic [npp_pkg::DW-1:0] bd_reg;
    logic bf_reg;
    logic [52:0] rtrial;
    logic [53:0] strial;
    logic signed [43:0] rx, ry;

    assign sts.skip = (len2_reg == '0);
    assign sts.div_done = !div_busy_reg && !cmd.div_start;
    assign sts.sqrt_done = !sq_busy_reg && !cmd.sqrt_start;
    assign rtrial = {drem_reg, 1'b0};
    assign strial = sres_reg + ({54'd1} << {scnt_reg, 1'b0});
    assign rx = ox_reg + 44'sd32768;
    assign ry = oy_reg + 44'sd32768;
    assign d_clamp = (sres_reg[53:25] != '0) ? npp_pkg::DIST_MAX : sres_reg[24:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            sq_busy_reg <= 1'b0;
            bf_reg <= 1'b0;
            t_reg <= '0;
        end
        else
        begin
            if (cmd.clr_best)
                bf_reg <= 1'b0;
            if (cmd.div_start)
            begin
                if (dp_reg <= 0)
                    t_reg <= 17'd0;
                else if (dp_reg >= $signed({1'b0, len2_reg[50:0]}))
                    t_reg <= 17'd65536;
                else
                begin
                    div_busy_reg <= 1'b1;
                    drem_reg <= dp_reg[51:0];
                    dq_reg <= '0;
                    dcnt_reg <= 5'd16;
                end
            end
            else if (div_busy_reg)
            begin
                if (rtrial >= {1'b0, len2_reg})
                begin
                    drem_reg <= 52'(rtrial - {1'b0, len2_reg});
                    dq_reg <= {dq_reg[14:0], 1'b1};
                end
                else
                begin
                    drem_reg <= rtrial[51:0];
                    dq_reg <= {dq_reg[14:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg - 5'd1;
                if (dcnt_reg == 5'd1)
                begin
                    div_busy_reg <= 1'b0;
                    t_reg <= {1'b0, dq_reg[14:0], rtrial >= {1'b0, len2_reg}};
                end
            end
            if (cmd.sqrt_start)
            begin
                sq_busy_reg <= 1'b1;
                sv_reg <= sq_reg;
                sres_reg <= '0;
                scnt_reg <= 6'd26;
            end
            else if (sq_busy_reg)
            begin
                if (sv_reg >= strial)
                begin
                    sv_reg <= sv_reg - strial;
                    sres_reg <= (sres_reg >> 1) + ({54'd1} << {scnt_reg, 1'b0});
                end
                else
                    sres_reg <= sres_reg >> 1;
                scnt_reg <= scnt_reg - 6'd1;
                if (scnt_reg == 6'd0)
                    sq_busy_reg <= 1'b0;
            end
            if (cmd.compare && (!bf_reg || d_clamp < bd_reg))
            begin
                bf_reg <= 1'b1;
                bd_reg <= d_clamp;
                bx_reg <= px_reg[23:0];
                by_reg <= py_reg[23:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_a)
        begin
            ax_reg <= 26'(rd_x);
            ay_reg <= 26'(rd_y);
            cax_reg <= 26'(cx) - 26'(rd_x);
            cay_reg <= 26'(cy) - 26'(rd_y);
        end
        if (cmd.load_b)
        begin
            abx_reg <= 26'(rd_x) - ax_reg;
            aby_reg <= 26'(rd_y) - ay_reg;
        end
        if (cmd.mul_dp)
        begin
            dp_reg <= 52'(cax_reg * abx_reg) + 52'(cay_reg * aby_reg);
            len2_reg <= 52'(abx_reg * abx_reg) + 52'(aby_reg * aby_reg);
        end
        if (cmd.mul_off)
        begin
            ox_reg <= 44'(abx_reg) * $signed({27'd0, t_reg});
            oy_reg <= 44'(aby_reg) * $signed({27'd0, t_reg});
        end
        if (cmd.form_pt)
        begin
            px_reg <= 27'(ax_reg) + 27'(rx >>> 16);
            py_reg <= 27'(ay_reg) + 27'(ry >>> 16);
        end
        if (cmd.mul_dd)
        begin
            dx_reg <= 27'(cx) - px_reg;
            dy_reg <= 27'(cy) - py_reg;
        end
        sq_reg <= 54'(dx_reg * dx_reg) + 54'(dy_reg * dy_reg);
    end

    assign best_x = bf_reg ? bx_reg : '0;
    assign best_y = bf_reg ? by_reg : '0;
    assign best_d = bf_reg ? bd_reg : '0;
    assign best_found = bf_reg;

    `NPP_ASSERT_NEXT(a_div_len, clk, rst_n, div_busy_reg, len2_reg != '0, "divide by zero length")
    `NPP_ASSERT_IMPL(a_t_rng, clk, rst_n, !div_busy_reg, t_reg <= 17'd65536, "t out of range")
    `NPP_ASSERT_IMPL(a_one_unit, clk, rst_n, 1'b1, !(div_busy_reg && sq_busy_reg), "units overlap")
endmodule

// ===== rtl/core/npp_ctrl.sv =====
`include "nearest_point_on_polyline_unit_defines.svh"
module npp_ctrl #(
    parameter int MAX_POINTS = npp_pkg::MAX_POINTS_DEF,
    parameter int AW = $clog2(MAX_POINTS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        req_type,
    output logic              busy,
    output npp_pkg::npp_cmd_t cmd,
    input  npp_pkg::npp_sts_t sts,
    output logic [AW-1:0]     rd_addr,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic              done,
    output logic              status,
    output logic              query_done
);
    localparam logic [3:0] S_IDLE = 4'd0, S_RDA = 4'd1, S_LA = 4'd2, S_LB = 4'd3,
        S_DP = 4'd4, S_DIVS = 4'd5, S_DIVW = 4'd6, S_OFF = 4'd7, S_PT = 4'd8,
        S_DD = 4'd9, S_SQ = 4'd10, S_SQS = 4'd11, S_SQW = 4'd12, S_NEXT = 4'd13,
        S_CHK = 4'd14;
    logic [3:0] state_reg, state_next;
    logic [AW:0] cnt_reg;
    logic [AW:0] seg_reg, seg_next;
    logic done_reg, done_next, st_reg, st_next, qd_reg, qd_next;
    logic [AW:0] cnt_next;

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign status = st_reg;
    assign query_done = qd_reg;
    assign wr_en = start && !busy && req_type == npp_pkg::REQ_APPEND &&
                   cnt_reg < (AW+1)'(MAX_POINTS);
    assign wr_addr = cnt_reg[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        seg_next = seg_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        st_next = 1'b0;
        qd_next = 1'b0;
        cmd = '0;
        rd_addr = seg_reg[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        npp_pkg::REQ_CLEAR:
                        begin
                            cnt_next = '0;
                            done_next = 1'b1;
                        end
                        npp_pkg::REQ_APPEND:
                        begin
                            done_next = 1'b1;
                            if (cnt_reg < (AW+1)'(MAX_POINTS))
                                cnt_next = cnt_reg + 1'b1;
                            else
                                st_next = 1'b1;
                        end
                        npp_pkg::REQ_QUERY:
                        begin
                            cmd.clr_best = 1'b1;
                            seg_next = '0;
                            state_next = S_CHK;
                        end
                        default:
                            done_next = 1'b1;
                    endcase
                end
            end
            S_CHK:
            begin
                if ({1'b0, seg_reg} + 1'b1 >= {1'b0, cnt_reg})
                begin
                    state_next = S_IDLE;
                    qd_next = 1'b1;
                    done_next = 1'b1;
                end
                else
                    state_next = S_RDA;
            end
            S_RDA:
            begin
                rd_addr = seg_reg[AW-1:0];
                state_next = S_LA;
            end
            S_LA:
            begin
                cmd.load_a = 1'b1;
                rd_addr = AW'(seg_reg + 1'b1);
                state_next = S_LB;
            end
            S_LB:
            begin
                cmd.load_b = 1'b1;
                state_next = S_DP;
            end
            S_DP:
            begin
                cmd.mul_dp = 1'b1;
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                if (sts.skip)
                    state_next = S_NEXT;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIVW;
                end
            end
            S_DIVW:
                if (sts.div_done)
                    state_next = S_OFF;
            S_OFF:
            begin
                cmd.mul_off = 1'b1;
                state_next = S_PT;
            end
            S_PT:
            begin
                cmd.form_pt = 1'b1;
                state_next = S_DD;
            end
            S_DD:
            begin
                cmd.mul_dd = 1'b1;
                state_next = S_SQ;
            end
            S_SQ:
                state_next = S_SQS;
            S_SQS:
            begin
                cmd.sqrt_start = 1'b1;
                state_next = S_SQW;
            end
            S_SQW:
                if (sts.sqrt_done)
                begin
                    cmd.compare = 1'b1;
                    state_next = S_NEXT;
                end
            S_NEXT:
            begin
                seg_next = seg_reg + 1'b1;
                state_next = S_CHK;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            seg_reg <= '0;
            done_reg <= 1'b0;
            st_reg <= 1'b0;
            qd_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            seg_reg <= seg_next;
            done_reg <= done_next;
            st_reg <= st_next;
            qd_reg <= qd_next;
        end
    end

    `NPP_ASSERT_IMPL(a_cnt_max, clk, rst_n, 1'b1, cnt_reg <= (AW+1)'(MAX_POINTS), "count over max")
    `NPP_ASSERT_NEXT(a_done_idle, clk, rst_n, done_next, state_reg == S_IDLE, "done while busy")
    `NPP_ASSERT_IMPL(a_st_done, clk, rst_n, st_reg, done_reg && !qd_reg, "status without done")
endmodule

// ===== rtl/core/nearest_point_on_polyline_unit.sv =====
// A query walks each segment in turn; a clamped t skips the divider and a zero-length
// segment skips both units (16-step divider, 27-step sqrt).
// Throughput: one item at a time; start is taken only while busy is low.
// Result strobe valid is high for one cycle; the receiver cannot stall.
// Reset (rst_n, async, active low) empties the vertex store and goes idle.
module nearest_point_on_polyline_unit #(
    parameter int MAX_POINTS = npp_pkg::MAX_POINTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    req_type,
    input  logic signed [npp_pkg::CW-1:0] px,
    input  logic signed [npp_pkg::CW-1:0] py,
    output logic                          valid,
    output logic signed [npp_pkg::CW-1:0] near_x,
    output logic signed [npp_pkg::CW-1:0] near_y,
    output logic [npp_pkg::DW-1:0]        near_dist,
    output logic                          found,
    output logic                          status
);
    localparam int AW = $clog2(MAX_POINTS);
    npp_pkg::npp_cmd_t cmd;
    npp_pkg::npp_sts_t sts;
    logic [AW-1:0] rd_addr, wr_addr;
    logic wr_en, qd;
    logic [2*npp_pkg::CW-1:0] mem [MAX_POINTS];
    logic [2*npp_pkg::CW-1:0] rd_reg;
    logic signed [npp_pkg::CW-1:0] cx_reg, cy_reg;
    logic signed [npp_pkg::CW-1:0] bx, by;
    logic [npp_pkg::DW-1:0] bd;
    logic bf;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= {px, py};
        rd_reg <= mem[rd_addr];
        if (start && !busy)
        begin
            cx_reg <= px;
            cy_reg <= py;
        end
    end

    npp_ctrl #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_ctrl (
        .clk, .rst_n, .start, .req_type, .busy, .cmd, .sts, .rd_addr,
        .wr_en, .wr_addr, .done(valid), .status, .query_done(qd)
    );

    npp_datapath u_dp (
        .clk, .rst_n, .cmd, .sts,
        .rd_x(rd_reg[2*npp_pkg::CW-1:npp_pkg::CW]), .rd_y(rd_reg[npp_pkg::CW-1:0]),
        .cx(cx_reg), .cy(cy_reg), .best_x(bx), .best_y(by), .best_d(bd),
        .best_found(bf)
    );

    assign near_x = qd ? bx : '0;
    assign near_y = qd ? by : '0;
    assign near_dist = qd ? bd : '0;
    assign found = qd & bf;
endmodule

// ===== tb/nearest_point_on_polyline_unit_tb.sv =====
`timescale 1ns / 100ps

module nearest_point_on_polyline_unit_tb;
    localparam int CW = npp_pkg::CW;
    localparam int DW = npp_pkg::DW;
    localparam logic [1:0] REQ_RSVD = 2'd3;
    localparam int STALL_LIMIT = 100000;

    typedef struct {
        logic signed [CW-1:0] nx;
        logic signed [CW-1:0] ny;
        logic [DW-1:0]        ndist;
        logic                 found;
        logic                 status;
    } near_result_t;

    class polyline_scoreboard;
        longint vx[npp_pkg::MAX_POINTS_DEF];
        longint vy[npp_pkg::MAX_POINTS_DEF];
        int unsigned nverts;
        near_result_t pending[$];
        int errors;
        int queries;
        int hits;

        function void clear_state();
            nverts = 0;
            pending.delete();
            errors = 0;
            queries = 0;
            hits = 0;
        endfunction

        function longint unsigned fraction16(longint unsigned num, longint unsigned den);
            longint unsigned q;
            longint unsigned r;
            q = 0;
            r = num;
            for (int i = 0; i < 16; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= den)
                begin
                    r = r - den;
                    q = q | 1;
                end
            end
            return q;
        endfunction

        function longint unsigned floor_sqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function longint scaled_offset(longint d, longint t);
            return (d * t + 32768) >>> 16;
        endfunction

        function void note_transfer(logic [1:0] req, logic signed [CW-1:0] x,
                                    logic signed [CW-1:0] y);
            near_result_t r;
            longint cx, cy, ax, ay, abx, aby, len2, dp, t, qx, qy, dx, dy;
            longint unsigned d, best;
            cx = x;
            cy = y;
            r = '{nx: '0, ny: '0, ndist: '0, found: 1'b0, status: 1'b0};
            best = 0;
            case (req)
                npp_pkg::REQ_CLEAR: nverts = 0;
                npp_pkg::REQ_APPEND:
                begin
                    if (nverts < npp_pkg::MAX_POINTS_DEF)
                    begin
                        vx[nverts] = cx;
                        vy[nverts] = cy;
                        nverts++;
                    end
                    else
                        r.status = 1'b1;
                end
                npp_pkg::REQ_QUERY:
                begin
                    queries++;
                    for (int i = 0; i + 1 < int'(nverts); i++)
                    begin
                        ax = vx[i];
                        ay = vy[i];
                        abx = vx[i+1] - ax;
                        aby = vy[i+1] - ay;
                        len2 = abx * abx + aby * aby;
                        dp = (cx - ax) * abx + (cy - ay) * aby;
                        if (len2 == 0)
                            continue;
                        if (dp <= 0)
                            t = 0;
                        else if (dp >= len2)
                            t = 65536;
                        else
                            t = fraction16(dp, len2);
                        qx = ax + scaled_offset(abx, t);
                        qy = ay + scaled_offset(aby, t);
                        dx = cx - qx;
                        dy = cy - qy;
                        d = floor_sqrt(dx * dx + dy * dy);
                        if (!r.found || d < best)
                        begin
                            best = d;
                            r.nx = qx[CW-1:0];
                            r.ny = qy[CW-1:0];
                            r.found = 1'b1;
                        end
                    end
                    if (best > npp_pkg::DIST_MAX)
                        best = npp_pkg::DIST_MAX;
                    r.ndist = best[DW-1:0];
                    if (r.found)
                        hits++;
                end
                default: ;
            endcase
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(near_result_t act);
            near_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: result with nothing outstanding: x=%0d y=%0d dist=%0d",
                         $time, act.nx, act.ny, act.ndist);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (act.nx !== e.nx)
            begin
                $display("%0t: near_x expected %0d actual %0d", $time, e.nx, act.nx);
                errors++;
            end
            if (act.ny !== e.ny)
            begin
                $display("%0t: near_y expected %0d actual %0d", $time, e.ny, act.ny);
                errors++;
            end
            if (act.ndist !== e.ndist)
            begin
                $display("%0t: near_dist expected %0d actual %0d", $time, e.ndist, act.ndist);
                errors++;
            end
            if (act.found !== e.found)
            begin
                $display("%0t: found expected %0b actual %0b", $time, e.found, act.found);
                errors++;
            end
            if (act.status !== e.status)
            begin
                $display("%0t: status expected %0b actual %0b", $time, e.status, act.status);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           req_type;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic                 valid;
    logic signed [CW-1:0] near_x;
    logic signed [CW-1:0] near_y;
    logic [DW-1:0]        near_dist;
    logic                 found;
    logic                 status;

    polyline_scoreboard sb;
    int idle_pct;
    int stall_cycles;
    int transfers;

    nearest_point_on_polyline_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .px        (px),
        .py        (py),
        .valid     (valid),
        .near_x    (near_x),
        .near_y    (near_y),
        .near_dist (near_dist),
        .found     (found),
        .status    (status)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note_transfer(req_type, px, py);
                transfers <= transfers + 1;
            end
            if (valid)
            begin
                sb.check_result('{nx: near_x, ny: near_y, ndist: near_dist,
                                  found: found, status: status});
            end
            if ((start && !busy) || valid)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send(logic [1:0] req, logic signed [CW-1:0] x, logic signed [CW-1:0] y);
        start <= 1'b1;
        req_type <= req;
        px <= x;
        py <= y;
        do
            @(posedge clk);
        while (busy);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            req_type <= 2'($urandom);
            px <= CW'($urandom);
            py <= CW'($urandom);
            @(posedge clk);
        end
    endtask

    function automatic logic signed [CW-1:0] pick_coord(int mode, int base);
        case (mode)
            0: return CW'($urandom);
            1: return CW'(base + int'($urandom_range(0, 2000)) - 1000);
            default: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
        endcase
    endfunction

    task automatic random_polyline();
        int nv, nq, mode, bx, by;
        logic signed [CW-1:0] lx, ly;
        mode = $urandom_range(9) < 6 ? 1 : ($urandom_range(9) < 8 ? 0 : 2);
        bx = int'($urandom_range(0, 16000000)) - 8000000;
        by = int'($urandom_range(0, 16000000)) - 8000000;
        nv = $urandom_range(9) == 0 ? $urandom_range(1) : $urandom_range(2, 7);
        nq = $urandom_range(1, 4);
        send(npp_pkg::REQ_CLEAR, CW'($urandom), CW'($urandom));
        lx = pick_coord(mode, bx);
        ly = pick_coord(mode, by);
        for (int i = 0; i < nv; i++)
        begin
            if (i == 0 || $urandom_range(9) != 0)
            begin
                lx = pick_coord(mode, bx);
                ly = pick_coord(mode, by);
            end
            send(npp_pkg::REQ_APPEND, lx, ly);
        end
        for (int i = 0; i < nq; i++)
        begin
            if ($urandom_range(19) == 0)
                send(REQ_RSVD, CW'($urandom), CW'($urandom));
            send(npp_pkg::REQ_QUERY, pick_coord($urandom_range(3) == 0 ? 0 : mode, bx),
                 pick_coord($urandom_range(3) == 0 ? 0 : mode, by));
        end
    endtask

    initial
    begin
        int pcts[4];
        sb = new();
        sb.clear_state();
        pcts = '{0, 46, 0, 10};
        idle_pct = 0;
        stall_cycles = 0;
        transfers = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req_type = npp_pkg::REQ_CLEAR;
        px = '0;
        py = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(npp_pkg::REQ_QUERY, 24'sd5, 24'sd5);
        send(npp_pkg::REQ_APPEND, 24'sd0, 24'sd0);
        send(npp_pkg::REQ_QUERY, 24'sd1, 24'sd1);
        send(npp_pkg::REQ_APPEND, 24'sd0, 24'sd0);
        send(npp_pkg::REQ_QUERY, 24'sd3, 24'sd4);
        send(npp_pkg::REQ_APPEND, 24'sh800000, 24'sh800000);
        send(npp_pkg::REQ_APPEND, 24'sh7fffff, 24'sh7fffff);
        send(npp_pkg::REQ_APPEND, 24'sh7fffff, 24'sh800000);
        send(npp_pkg::REQ_QUERY, 24'sh800000, 24'sh7fffff);
        send(npp_pkg::REQ_QUERY, 24'sh7fffff, 24'sh800000);
        send(npp_pkg::REQ_QUERY, 24'sd0, 24'sd0);
        send(npp_pkg::REQ_QUERY, -24'sd3, 24'sd100);
        send(REQ_RSVD, 24'sh7fffff, 24'sh800000);
        send(npp_pkg::REQ_QUERY, 24'sh555555, -24'sh2aaaaa);
        send(npp_pkg::REQ_CLEAR, 24'sh7fffff, 24'sh7fffff);
        send(npp_pkg::REQ_QUERY, 24'sd0, 24'sd0);
        send(npp_pkg::REQ_APPEND, 24'sd0, 24'sd0);
        send(npp_pkg::REQ_APPEND, 24'sd3, 24'sd0);
        send(npp_pkg::REQ_QUERY, 24'sd1, 24'sd1);
        send(npp_pkg::REQ_QUERY, 24'sd2, -24'sd1);

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = pcts[p];
            for (int k = 0; k < 3; k++)
                random_polyline();
        end

        send(npp_pkg::REQ_CLEAR, '0, '0);
        start <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Sent %0d transfers, %0d queries (%0d with a nearest point),",
                 transfers, sb.queries, sb.hits);
        $display("over idle rates 0/46/10 percent on short random polylines.");
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
